// File: hdl/i2cbm_pkg.sv
// Types and constants shared by the byte-level I2C master and its checker.
package i2cbm_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int HALF_PERIOD_W   = 16;
	localparam int BYTE_W          = 8;
	localparam int BIT_COUNT_W     = 4;
	localparam int CFG_INDEX_W     = 1;

	localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd250;

	typedef enum logic [1:0] {
		FN_START = 2'd0,
		FN_STOP  = 2'd1,
		FN_WRITE = 2'd2,
		FN_READ  = 2'd3
	} func_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HALF_PERIOD   = 1'd0,
		REG_SCL_PUSH_PULL = 1'd1
	} cfg_reg_t;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_LEAD     = 6'b000010,
		ST_BIT_HIGH = 6'b000100,
		ST_BIT_LOW  = 6'b001000,
		ST_ACK_HIGH = 6'b010000,
		ST_ACK_LOW  = 6'b100000
	} step_t;

	typedef struct packed {
		logic              cmd_valid;
		logic [1:0]        func;
		logic [BYTE_W-1:0] tx_byte;
		logic              last_read;
		logic              sda_in;
	} in_item_t;

	typedef struct packed {
		logic              scl_drive_low;
		logic              scl_drive_high;
		logic              sda_drive_low;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] rx_byte;
		logic              ack_ok;
	} out_item_t;

endpackage

// File: hdl/i2c_byte_master.sv
// Byte-level I2C master: phase sequencer for start, stop, write and read.
// An accepted item's result is registered in the output register, or in skid while stalled.
// Throughput: one item per cycle unless the skid is full; phase timer advances once per item.
// A two-entry output stage (output register plus skid) keeps input ready while a result waits.
// Reset: asynchronous, active low; sequencer idle, SCL and SDA released,
// half_period 250, push-pull off, output stage empty.
module i2c_byte_master #(
	parameter int COUNT_WIDTH = i2cbm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  i2cbm_pkg::in_item_t                     in_item,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output i2cbm_pkg::out_item_t                    out_item,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [i2cbm_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [i2cbm_pkg::HALF_PERIOD_W-1:0]     cfg_data
);
	import i2cbm_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > HALF_PERIOD_W) ? COUNT_WIDTH : HALF_PERIOD_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

	logic [HALF_PERIOD_W-1:0] half_period_q;
	logic                     push_pull_q;

	step_t                    step_q, step_d;
	logic [COUNT_WIDTH-1:0]   count_q, count_d;
	logic [BIT_COUNT_W-1:0]   bits_q, bits_d;
	logic [BYTE_W-1:0]        shift_q, shift_d;
	logic                     scl_low_q, scl_low_d;
	logic                     sda_low_q, sda_low_d;
	logic                     ack_q, ack_d;
	func_t                    op_q, op_d;
	logic                     last_q, last_d;
	logic [BYTE_W-1:0]        rx_q, rx_d;

	logic                     done_d;
	logic                     do_begin;
	step_t                    begin_st;
	logic                     phase_run;
	out_item_t                res_d;

	out_item_t                out_q, skid_q;
	logic                     out_v_q, skid_v_q;
	logic                     in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_v_q;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_v_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
			push_pull_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_HALF_PERIOD:   half_period_q <= cfg_data;
				REG_SCL_PUSH_PULL: push_pull_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign phase_run = (CMP_W'(count_q) < CMP_W'(half_period_q)) && (count_q != COUNT_MAX);

	always_comb begin
		step_d    = step_q;
		count_d   = count_q;
		bits_d    = bits_q;
		shift_d   = shift_q;
		scl_low_d = scl_low_q;
		sda_low_d = sda_low_q;
		ack_d     = ack_q;
		op_d      = op_q;
		last_d    = last_q;
		rx_d      = rx_q;
		done_d    = 1'b0;
		do_begin  = 1'b0;
		begin_st  = ST_LEAD;

		if (step_q == ST_IDLE) begin
			if (in_item.cmd_valid) begin
				op_d     = func_t'(in_item.func);
				last_d   = in_item.last_read;
				bits_d   = '0;
				shift_d  = (func_t'(in_item.func) == FN_WRITE) ? in_item.tx_byte : '0;
				do_begin = 1'b1;
				begin_st = ST_LEAD;
			end
		end else if (phase_run) begin
			count_d = count_q + COUNT_ONE;
		end else begin
			case (step_q)
				ST_LEAD: begin
					do_begin = 1'b1;
					begin_st = (op_q == FN_START || op_q == FN_STOP) ? ST_ACK_HIGH : ST_BIT_HIGH;
				end
				ST_BIT_HIGH: begin
					shift_d  = {shift_q[BYTE_W-2:0], (op_q == FN_READ) && in_item.sda_in};
					bits_d   = bits_q + BIT_COUNT_W'(1);
					do_begin = 1'b1;
					begin_st = ST_BIT_LOW;
				end
				ST_BIT_LOW: begin
					do_begin = 1'b1;
					begin_st = bits_q[BIT_COUNT_W-1] ? ST_ACK_HIGH : ST_BIT_HIGH;
				end
				ST_ACK_HIGH: begin
					if (op_q == FN_WRITE) begin
						ack_d = !in_item.sda_in;
					end
					if (op_q == FN_START || op_q == FN_STOP) begin
						sda_low_d = (op_q == FN_START);
						step_d    = ST_IDLE;
						count_d   = '0;
						done_d    = 1'b1;
					end else begin
						do_begin = 1'b1;
						begin_st = ST_ACK_LOW;
					end
				end
				ST_ACK_LOW: begin
					sda_low_d = 1'b0;
					if (op_q == FN_READ) begin
						rx_d = shift_q;
					end
					step_d  = ST_IDLE;
					count_d = '0;
					done_d  = 1'b1;
				end
				default: begin
					step_d  = ST_IDLE;
					count_d = '0;
				end
			endcase
		end

		if (do_begin) begin
			step_d  = begin_st;
			count_d = COUNT_ONE;
			case (begin_st)
				ST_BIT_HIGH: begin
					scl_low_d = 1'b0;
					sda_low_d = (op_d == FN_WRITE) ? !shift_d[BYTE_W-1] : 1'b0;
				end
				ST_ACK_HIGH: begin
					scl_low_d = 1'b0;
					if (op_d == FN_STOP) begin
						sda_low_d = 1'b1;
					end else if (op_d == FN_READ) begin
						sda_low_d = !last_d;
					end else begin
						sda_low_d = 1'b0;
					end
				end
				default: scl_low_d = 1'b1;
			endcase
		end

		res_d.scl_drive_low  = scl_low_d;
		res_d.scl_drive_high = push_pull_q && !scl_low_d;
		res_d.sda_drive_low  = sda_low_d;
		res_d.busy_res       = (step_d != ST_IDLE);
		res_d.done_res       = done_d;
		res_d.rx_byte        = rx_d;
		res_d.ack_ok         = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= ST_IDLE;
			count_q   <= '0;
			bits_q    <= '0;
			shift_q   <= '0;
			scl_low_q <= 1'b0;
			sda_low_q <= 1'b0;
			ack_q     <= 1'b0;
			op_q      <= FN_START;
			last_q    <= 1'b0;
			rx_q      <= '0;
		end else if (in_fire) begin
			step_q    <= step_d;
			count_q   <= count_d;
			bits_q    <= bits_d;
			shift_q   <= shift_d;
			scl_low_q <= scl_low_d;
			sda_low_q <= sda_low_d;
			ack_q     <= ack_d;
			op_q      <= op_d;
			last_q    <= last_d;
			rx_q      <= rx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res_d;
			end
		end else if (in_fire) begin
			skid_q <= res_d;
		end
	end

endmodule

// File: hdl/i2cbm_checker.sv
// Port-level checker for the byte-level I2C master, bound into every i2c_byte_master instance.
module i2cbm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input i2cbm_pkg::out_item_t                out_item
);
	import i2cbm_pkg::*;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output item changed while stalled");

	a_skid_only_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with the output stage empty");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.done_res |-> !out_item.busy_res)
		else $error("done item still shows busy");

	a_scl_drive_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.scl_drive_high && out_item.scl_drive_low))
		else $error("SCL driven high and low together");

endmodule

bind i2c_byte_master i2cbm_checker u_i2cbm_checker (.*);

// File: bench/tb_i2c_byte_master.sv
// Self-checking bench for the byte-level I2C master: per-tick bus level prediction and compare.
module tb_i2c_byte_master;
	timeunit 1ns;
	timeprecision 1ps;
	import i2cbm_pkg::*;

	localparam int TICK_LIMIT  = 200000;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_AFTER  = 250;
	localparam int HOLD_CYCLES = 60;

	localparam out_item_t LEVELS_IDLE_PP    = {1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0};
	localparam out_item_t LEVELS_START_LEAD = {1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0};
	localparam out_item_t LEVELS_ANY        = '0;

	typedef struct packed {
		in_item_t   tick;
		logic [7:0] reps;
		logic       typed;
		out_item_t  want;
	} script_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	in_item_t                 in_item;
	logic                     out_valid;
	logic                     out_ready;
	out_item_t                out_item;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_INDEX_W-1:0]   cfg_index;
	logic [HALF_PERIOD_W-1:0] cfg_data;

	logic [15:0] half_q;
	logic        pp_q;
	step_t       seq_step;
	logic [15:0] phase_cnt;
	logic [3:0]  bit_cnt;
	logic [7:0]  shift_q;
	logic        scl_low;
	logic        sda_low;
	logic        ack_q;
	func_t       cur_op;
	logic        last_q;
	logic [7:0]  rx_q;

	out_item_t bus_levels_q [$];
	int levels_pending = 0;
	int levels_seen    = 0;
	int mismatches     = 0;
	int send_calm      = 0;
	int take_calm      = 0;
	int cycle_cnt      = 0;

	script_row_t script [16] = '{
		{{1'b0, FN_START, 8'h00, 1'b0, 1'b1}, 8'd1,  1'b1, LEVELS_IDLE_PP},
		{{1'b1, FN_START, 8'h00, 1'b0, 1'b1}, 8'd1,  1'b1, LEVELS_START_LEAD},
		{{1'b0, FN_START, 8'hFF, 1'b1, 1'b0}, 8'd1,  1'b0, LEVELS_ANY},
		{{1'b1, FN_WRITE, 8'hFF, 1'b0, 1'b1}, 8'd1,  1'b0, LEVELS_ANY},
		{{1'b1, FN_WRITE, 8'h00, 1'b0, 1'b1}, 8'd1,  1'b0, LEVELS_ANY},
		{{1'b0, FN_READ,  8'h5A, 1'b1, 1'b1}, 8'd8,  1'b0, LEVELS_ANY},
		{{1'b1, FN_STOP,  8'h00, 1'b0, 1'b1}, 8'd1,  1'b0, LEVELS_ANY},
		{{1'b0, FN_WRITE, 8'h00, 1'b0, 1'b0}, 8'd10, 1'b0, LEVELS_ANY},
		{{1'b1, FN_READ,  8'hFF, 1'b0, 1'b1}, 8'd1,  1'b0, LEVELS_ANY},
		{{1'b0, FN_WRITE, 8'h00, 1'b0, 1'b1}, 8'd19, 1'b0, LEVELS_ANY},
		{{1'b1, FN_READ,  8'h00, 1'b1, 1'b0}, 8'd1,  1'b0, LEVELS_ANY},
		{{1'b0, FN_START, 8'hFF, 1'b1, 1'b0}, 8'd19, 1'b0, LEVELS_ANY},
		{{1'b1, FN_WRITE, 8'hFF, 1'b1, 1'b1}, 8'd1,  1'b0, LEVELS_ANY},
		{{1'b0, FN_STOP,  8'hAA, 1'b0, 1'b1}, 8'd19, 1'b0, LEVELS_ANY},
		{{1'b1, FN_STOP,  8'h00, 1'b0, 1'b0}, 8'd1,  1'b0, LEVELS_ANY},
		{{1'b0, FN_STOP,  8'h00, 1'b0, 1'b1}, 8'd2,  1'b0, LEVELS_ANY}
	};

	i2c_byte_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= TICK_LIMIT) begin
			$display("tb_i2c_byte_master: FAIL");
			$finish;
		end
	end

	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			calm = 40;
			return 0;
		end
		return int'($urandom_range(0, 4));
	endfunction

	function automatic void enter_phase(input step_t s);
		seq_step  = s;
		phase_cnt = 16'd1;
		case (s)
			ST_BIT_HIGH: begin
				scl_low = 1'b0;
				sda_low = (cur_op == FN_WRITE) ? ~shift_q[7] : 1'b0;
			end
			ST_ACK_HIGH: begin
				scl_low = 1'b0;
				if (cur_op == FN_STOP)
					sda_low = 1'b1;
				else if (cur_op == FN_READ)
					sda_low = ~last_q;
				else
					sda_low = 1'b0;
			end
			default: scl_low = 1'b1;
		endcase
	endfunction

	function automatic void finish_command();
		sda_low = (cur_op == FN_START);
		if (cur_op == FN_READ)
			rx_q = shift_q;
		seq_step  = ST_IDLE;
		phase_cnt = '0;
	endfunction

	function automatic out_item_t advance_bus_tick(input in_item_t tick);
		out_item_t lv;
		logic      done;
		done = 1'b0;
		if (seq_step == ST_IDLE) begin
			if (tick.cmd_valid) begin
				cur_op  = func_t'(tick.func);
				last_q  = tick.last_read;
				bit_cnt = '0;
				shift_q = (cur_op == FN_WRITE) ? tick.tx_byte : 8'h00;
				enter_phase(ST_LEAD);
			end
		end else if (phase_cnt < half_q && phase_cnt != 16'hFFFF) begin
			phase_cnt++;
		end else begin
			case (seq_step)
				ST_LEAD: begin
					if (cur_op == FN_START || cur_op == FN_STOP)
						enter_phase(ST_ACK_HIGH);
					else
						enter_phase(ST_BIT_HIGH);
				end
				ST_BIT_HIGH: begin
					shift_q = {shift_q[6:0], (cur_op == FN_READ) ? tick.sda_in : 1'b0};
					bit_cnt++;
					enter_phase(ST_BIT_LOW);
				end
				ST_BIT_LOW: begin
					if (bit_cnt >= 4'd8)
						enter_phase(ST_ACK_HIGH);
					else
						enter_phase(ST_BIT_HIGH);
				end
				ST_ACK_HIGH: begin
					if (cur_op == FN_WRITE)
						ack_q = ~tick.sda_in;
					if (cur_op == FN_START || cur_op == FN_STOP) begin
						finish_command();
						done = 1'b1;
					end else begin
						enter_phase(ST_ACK_LOW);
					end
				end
				ST_ACK_LOW: begin
					finish_command();
					done = 1'b1;
				end
				default: begin
					seq_step  = ST_IDLE;
					phase_cnt = '0;
				end
			endcase
		end
		lv.scl_drive_low  = scl_low;
		lv.scl_drive_high = pp_q & ~scl_low;
		lv.sda_drive_low  = sda_low;
		lv.busy_res       = (seq_step != ST_IDLE);
		lv.done_res       = done;
		lv.rx_byte        = rx_q;
		lv.ack_ok         = ack_q;
		return lv;
	endfunction

	task automatic send_tick(input in_item_t tick, input logic typed, input out_item_t want);
		int        gap;
		out_item_t lv;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= tick;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		lv = advance_bus_tick(tick);
		bus_levels_q.push_back(typed ? want : lv);
		levels_pending++;
	endtask

	task automatic set_bus_timing(input logic [15:0] half, input logic push_pull);
		cfg_reg_t    regs [2];
		logic [15:0] vals [2];
		regs[0] = REG_HALF_PERIOD;
		regs[1] = REG_SCL_PUSH_PULL;
		vals[0] = half;
		vals[1] = {15'd0, push_pull};
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			if (regs[i] == REG_HALF_PERIOD)
				half_q = vals[i];
			else
				pp_q = vals[i][0];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic settle_bus();
		in_valid <= 1'b0;
		wait (levels_pending == 0);
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [15:0] half, input logic push_pull, input int count);
		in_item_t tick;
		settle_bus();
		set_bus_timing(half, push_pull);
		repeat (count) begin
			if (seq_step == ST_IDLE)
				tick.cmd_valid = ($urandom_range(0, 9) < 8);
			else
				tick.cmd_valid = ($urandom_range(0, 19) == 0);
			tick.func      = 2'($urandom_range(0, 3));
			tick.tx_byte   = 8'($urandom_range(0, 255));
			tick.last_read = 1'($urandom_range(0, 1));
			tick.sda_in    = 1'($urandom_range(0, 1));
			send_tick(tick, 1'b0, LEVELS_ANY);
		end
	endtask

	initial begin : take_levels
		int        stall;
		out_item_t want;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = (levels_seen == HOLD_AFTER) ? HOLD_CYCLES : draw_wait(take_calm);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			levels_seen++;
			if (bus_levels_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected item %0d: %p", levels_seen, out_item);
			end else begin
				want = bus_levels_q.pop_front();
				levels_pending--;
				if (out_item !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("item %0d want scl_lo %b scl_hi %b sda_lo %b busy %b done %b rx %h ack %b",
							levels_seen, want.scl_drive_low, want.scl_drive_high,
							want.sda_drive_low, want.busy_res, want.done_res, want.rx_byte,
							want.ack_ok);
						$display("item %0d got  scl_lo %b scl_hi %b sda_lo %b busy %b done %b rx %h ack %b",
							levels_seen, out_item.scl_drive_low, out_item.scl_drive_high,
							out_item.sda_drive_low, out_item.busy_res, out_item.done_res,
							out_item.rx_byte, out_item.ack_ok);
					end
				end
			end
		end
	end

	initial begin : drive_stimulus
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_HALF_PERIOD;
		cfg_data  <= '0;
		half_q    = HALF_PERIOD_RST;
		pp_q      = 1'b0;
		seq_step  = ST_IDLE;
		phase_cnt = '0;
		bit_cnt   = '0;
		shift_q   = '0;
		scl_low   = 1'b0;
		sda_low   = 1'b0;
		ack_q     = 1'b0;
		cur_op    = FN_START;
		last_q    = 1'b0;
		rx_q      = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_bus_timing(16'd1, 1'b1);
		foreach (script[r])
			repeat (script[r].reps) send_tick(script[r].tick, script[r].typed, script[r].want);

		run_phase(16'd1, 1'b0, 650);
		run_phase(16'd0, 1'b1, 300);
		run_phase(16'd3, 1'b0, 250);
		run_phase(16'd2, 1'b1, 250);
		run_phase(16'hFFFF, 1'b0, 60);
		run_phase(16'd1, 1'b1, 100);

		settle_bus();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb_i2c_byte_master: PASS");
		else
			$display("tb_i2c_byte_master: FAIL");
		$finish;
	end

endmodule
